>>> hw/rtl/rgl_pkg.sv
// Shared types and constants for the running GCD/LCM block.
// Used by rgl_unit and running_gcd_lcm; depends on nothing.
`timescale 1ns / 1ps

package rgl_pkg;

    // Input item kinds carried on s_tuser
    localparam logic OPC_START  = 1'b0;
    localparam logic OPC_EXTEND = 1'b1;

    // Operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        RGL_OP_GCD,
        RGL_OP_DIV,
        RGL_OP_MUL
    } rgl_op_t;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic    start;
        rgl_op_t op;
    } rgl_req_t;

    // Status from the arithmetic unit back to the sequencer
    typedef struct packed {
        logic done;
        logic over;
    } rgl_rsp_t;

    // Arithmetic unit states
    typedef enum logic [1:0] {
        CU_IDLE,
        CU_GCD,
        CU_DIV,
        CU_MUL
    } rgl_unit_state_t;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_A,
        ST_GCD_L,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } rgl_state_t;

endpackage

>>> hw/rtl/rgl_unit.sv
// Iterative arithmetic unit: binary GCD, restoring divide and shift-add multiply
// around one shared adder/subtractor. Depends on rgl_pkg.
`timescale 1ns / 1ps

module rgl_unit #(
    parameter int WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rgl_pkg::rgl_req_t   req,
    input  logic [WIDTH-1:0]    op_x,
    input  logic [WIDTH-1:0]    op_y,
    output rgl_pkg::rgl_rsp_t   rsp,
    output logic [WIDTH-1:0]    res
);

    localparam int CNT_W = $clog2(WIDTH + 1);
    localparam int AW    = WIDTH + 2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    rgl_pkg::rgl_unit_state_t state_reg, state_next;

    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] z_reg, z_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             over_reg, over_next;
    logic             done_reg, done_next;

    logic [AW-1:0]    add_a;
    logic [AW-1:0]    add_b;
    logic             add_sub;
    logic [AW-1:0]    add_sum;
    logic             div_ge;
    logic [WIDTH:0]   mul_s;

    // Shared adder/subtractor
    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
    assign div_ge  = ~add_sum[AW-1];
    assign mul_s   = x_reg[0] ? add_sum[WIDTH:0] : {1'b0, z_reg};

    // Select operands of the shared adder
    always_comb
    begin
        add_a   = {2'b00, x_reg};
        add_b   = {2'b00, y_reg};
        add_sub = 1'b1;
        unique case (state_reg)
            rgl_pkg::CU_DIV:
            begin
                add_a = {1'b0, z_reg, x_reg[WIDTH-1]};
            end
            rgl_pkg::CU_MUL:
            begin
                add_a   = {2'b00, z_reg};
                add_sub = 1'b0;
            end
            default:
            begin
                add_sub = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rgl_pkg::CU_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        rgl_pkg::RGL_OP_DIV: state_next = rgl_pkg::CU_DIV;
                        rgl_pkg::RGL_OP_MUL: state_next = rgl_pkg::CU_MUL;
                        default:             state_next = rgl_pkg::CU_GCD;
                    endcase
                end
            end
            rgl_pkg::CU_GCD:
            begin
                if ((x_reg == '0) || (y_reg == '0))
                    state_next = rgl_pkg::CU_IDLE;
            end
            default:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = rgl_pkg::CU_IDLE;
            end
        endcase
    end

    // Datapath updates
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        over_next = over_reg;
        done_next = (state_reg != rgl_pkg::CU_IDLE) && (state_next == rgl_pkg::CU_IDLE);
        unique case (state_reg)
            rgl_pkg::CU_IDLE:
            begin
                // load operands
                if (req.start)
                begin
                    x_next    = op_x;
                    y_next    = op_y;
                    z_next    = '0;
                    cnt_next  = '0;
                    over_next = 1'b0;
                end
            end
            rgl_pkg::CU_GCD:
            begin
                // one binary GCD step; cnt holds the shared power of two
                if (x_reg == '0)
                    x_next = y_reg << cnt_reg;
                else if (y_reg == '0)
                    x_next = x_reg << cnt_reg;
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next   = x_reg >> 1;
                    y_next   = y_reg >> 1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (!x_reg[0])
                    x_next = x_reg >> 1;
                else if (!y_reg[0])
                    y_next = y_reg >> 1;
                else if (div_ge)
                    x_next = add_sum[WIDTH-1:0];
                else
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            rgl_pkg::CU_DIV:
            begin
                // one quotient bit per cycle, remainder in z
                z_next   = div_ge ? add_sum[WIDTH-1:0] : {z_reg[WIDTH-2:0], x_reg[WIDTH-1]};
                x_next   = {x_reg[WIDTH-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            default:
            begin
                // add and shift; {z, x} ends as the full product
                z_next    = mul_s[WIDTH:1];
                x_next    = {mul_s[0], x_reg[WIDTH-1:1]};
                cnt_next  = cnt_reg + CNT_W'(1);
                over_next = (|mul_s[WIDTH:1]) || (&{mul_s[0], x_reg[WIDTH-1:1]});
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgl_pkg::CU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cnt_reg  <= cnt_next;
        over_reg <= over_next;
    end

    assign rsp.done = done_reg;
    assign rsp.over = over_reg;
    assign res      = x_reg;

endmodule

>>> hw/rtl/running_gcd_lcm.sv
// Top level of the running GCD/LCM block: stream ports, sequencer, set state
// and output register. Depends on rgl_pkg and rgl_unit.
`timescale 1ns / 1ps
//
//  Channel   Dir   Handshake          Payload
//  --------  ----  -----------------  --------------------------------------------
//  s_*       in    s_tvalid/s_tready  tuser: opcode; tdata: value_a, value_b
//  m_*       out   m_tvalid/m_tready  tdata: gcd_out, lcm_out; tuser: over_capacity
//
//  One request at a time through a single shared adder unit: a start request
//  takes a binary GCD (data dependent), a divide and a multiply through the
//  sequencer states; an extend request takes two GCDs before the divide and
//  multiply. A flagged request goes straight to the output state. s_tready is
//  high only in the idle state; a finished result waits in the output register
//  while the next request is taken.
//  Reset clears GCD, LCM and the flag to zero.

module running_gcd_lcm #(
    parameter int WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] value_a, [63:32] value_b
    input  logic        s_tuser,    // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] gcd_out, [63:32] lcm_out
    output logic        m_tuser     // [0] over_capacity
);

    localparam int CW = (WIDTH > 32) ? WIDTH : 32;
    localparam logic [WIDTH-1:0] CAP = '1;

    rgl_pkg::rgl_state_t state_reg, state_next;
    rgl_pkg::rgl_req_t   core_req;
    rgl_pkg::rgl_rsp_t   core_rsp;

    logic [WIDTH-1:0] op_x;
    logic [WIDTH-1:0] op_y;
    logic [WIDTH-1:0] core_res;

    logic [WIDTH-1:0] gcd_reg, gcd_next;
    logic [WIDTH-1:0] lcm_reg, lcm_next;
    logic             flag_reg, flag_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic             ext_reg, ext_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_gcd_reg;
    logic [31:0]      out_lcm_reg;
    logic             out_flag_reg;

    logic [31:0]      a_in;
    logic [31:0]      b_in;
    logic             accept;
    logic             a_over;
    logic             b_over;
    logic [31:0]      max_in;
    logic [31:0]      min_in;
    logic             out_free;
    logic             out_load;

    // Decode the input request
    assign a_in     = s_tdata[31:0];
    assign b_in     = s_tdata[63:32];
    assign s_tready = (state_reg == rgl_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign a_over   = CW'(a_in) >= CW'(CAP);
    assign b_over   = CW'(b_in) >= CW'(CAP);
    assign max_in   = (a_in > b_in) ? a_in : b_in;
    assign min_in   = (a_in > b_in) ? b_in : a_in;
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == rgl_pkg::ST_OUT) && out_free;

    rgl_unit #(
        .WIDTH (WIDTH)
    ) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (core_req),
        .op_x  (op_x),
        .op_y  (op_y),
        .rsp   (core_rsp),
        .res   (core_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rgl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == rgl_pkg::OPC_EXTEND)
                        state_next = (flag_reg || a_over) ? rgl_pkg::ST_OUT
                                                          : rgl_pkg::ST_GCD_A;
                    else
                        state_next = (a_over || b_over) ? rgl_pkg::ST_OUT
                                                        : rgl_pkg::ST_GCD_A;
                end
            end
            rgl_pkg::ST_GCD_A:
            begin
                if (core_rsp.done)
                begin
                    if (ext_reg)
                        state_next = rgl_pkg::ST_GCD_L;
                    else
                        state_next = (core_res == '0) ? rgl_pkg::ST_OUT : rgl_pkg::ST_DIV;
                end
            end
            rgl_pkg::ST_GCD_L:
            begin
                if (core_rsp.done)
                    state_next = (core_res == '0) ? rgl_pkg::ST_OUT : rgl_pkg::ST_DIV;
            end
            rgl_pkg::ST_DIV:
            begin
                if (core_rsp.done)
                    state_next = rgl_pkg::ST_MUL;
            end
            rgl_pkg::ST_MUL:
            begin
                if (core_rsp.done)
                    state_next = rgl_pkg::ST_OUT;
            end
            rgl_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = rgl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rgl_pkg::ST_IDLE;
            end
        endcase
    end

    // Issue operations to the arithmetic unit
    always_comb
    begin
        core_req.start = 1'b0;
        core_req.op    = rgl_pkg::RGL_OP_GCD;
        op_x           = a_reg;
        op_y           = b_reg;
        unique case (state_reg)
            rgl_pkg::ST_IDLE:
            begin
                if (state_next == rgl_pkg::ST_GCD_A)
                begin
                    core_req.start = 1'b1;
                    if (s_tuser == rgl_pkg::OPC_EXTEND)
                    begin
                        op_x = WIDTH'(a_in);
                        op_y = gcd_reg;
                    end
                    else
                    begin
                        op_x = WIDTH'(max_in);
                        op_y = WIDTH'(min_in);
                    end
                end
            end
            rgl_pkg::ST_GCD_A,
            rgl_pkg::ST_GCD_L:
            begin
                if (state_next == rgl_pkg::ST_GCD_L)
                begin
                    core_req.start = 1'b1;
                end
                else if (state_next == rgl_pkg::ST_DIV)
                begin
                    core_req.start = 1'b1;
                    core_req.op    = rgl_pkg::RGL_OP_DIV;
                    op_y           = core_res;
                end
            end
            rgl_pkg::ST_DIV:
            begin
                if (core_rsp.done)
                begin
                    core_req.start = 1'b1;
                    core_req.op    = rgl_pkg::RGL_OP_MUL;
                    op_x           = core_res;
                end
            end
            default:
            begin
                core_req.start = 1'b0;
            end
        endcase
    end

    // Update set state and operand registers
    always_comb
    begin
        gcd_next       = gcd_reg;
        lcm_next       = lcm_reg;
        flag_next      = flag_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ext_next       = ext_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            rgl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ext_next = (s_tuser == rgl_pkg::OPC_EXTEND);
                    if (s_tuser == rgl_pkg::OPC_EXTEND)
                    begin
                        flag_next = flag_reg || a_over;
                        a_next    = WIDTH'(a_in);
                        b_next    = lcm_reg;
                    end
                    else
                    begin
                        flag_next = a_over || b_over;
                        a_next    = WIDTH'(max_in);
                        b_next    = WIDTH'(min_in);
                    end
                end
            end
            rgl_pkg::ST_GCD_A:
            begin
                if (core_rsp.done)
                begin
                    gcd_next = core_res;
                    if (!ext_reg && (core_res == '0))
                        lcm_next = '0;
                end
            end
            rgl_pkg::ST_GCD_L:
            begin
                if (core_rsp.done && (core_res == '0))
                    lcm_next = '0;
            end
            rgl_pkg::ST_MUL:
            begin
                // saturate on overflow, flag a zero product
                if (core_rsp.done)
                begin
                    if (core_rsp.over)
                    begin
                        lcm_next  = CAP;
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        lcm_next  = core_res;
                        flag_next = flag_reg || (core_res == '0);
                    end
                end
            end
            rgl_pkg::ST_OUT:
            begin
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                ext_next = ext_reg;
            end
        endcase
    end

    // Control and set state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rgl_pkg::ST_IDLE;
            gcd_reg       <= '0;
            lcm_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gcd_reg       <= gcd_next;
            lcm_reg       <= lcm_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Operand and result payload
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        ext_reg <= ext_next;
        if (out_load)
        begin
            out_gcd_reg  <= 32'(gcd_reg);
            out_lcm_reg  <= 32'(lcm_reg);
            out_flag_reg <= flag_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_lcm_reg, out_gcd_reg};
    assign m_tuser  = out_flag_reg;

`ifndef SYNTHESIS
    // The unit finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        core_rsp.done |-> (state_reg == rgl_pkg::ST_GCD_A) || (state_reg == rgl_pkg::ST_GCD_L)
                       || (state_reg == rgl_pkg::ST_DIV) || (state_reg == rgl_pkg::ST_MUL))
        else $error("arithmetic unit done outside a wait state");

    // An accepted request leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != rgl_pkg::ST_IDLE))
        else $error("sequencer stayed idle after accepting a request");

    // Overflow saturates the LCM and sets the flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rgl_pkg::ST_MUL) && core_rsp.done && core_rsp.over
        |=> flag_reg && (lcm_reg == CAP))
        else $error("product overflow not saturated");

    // The sticky flag clears only on a start request
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(flag_reg) |-> $past(accept && (s_tuser == rgl_pkg::OPC_START)))
        else $error("invalid flag cleared outside a start request");

    // A result is loaded only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(out_gcd_reg) && $stable(out_lcm_reg))
        else $error("pending result overwritten");
`endif

endmodule
